@@ rtl/core/rrfp_pkg.sv @@
// Shared types and constants for the request/response frame parser.
// No dependencies; imported by every module of the block.
package rrfp_pkg;

	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgDataW = 17;

	// configuration register indexes
	localparam logic [CfgIdxW-1:0] REG_FRAME_KIND = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_PATH_LIMIT = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_PARAMS_LIMIT = 2'd2;

	// byte classes
	localparam logic [3:0] CLS_FRAME_LEN = 4'd0;
	localparam logic [3:0] CLS_TYPE = 4'd1;
	localparam logic [3:0] CLS_PATH_LEN = 4'd2;
	localparam logic [3:0] CLS_PATH = 4'd3;
	localparam logic [3:0] CLS_PARAMS_LEN = 4'd4;
	localparam logic [3:0] CLS_PARAMS = 4'd5;
	localparam logic [3:0] CLS_PAYLOAD_LEN = 4'd6;
	localparam logic [3:0] CLS_PAYLOAD = 4'd7;
	localparam logic [3:0] CLS_TRAILING = 4'd8;
	localparam logic [3:0] CLS_DISCARDED = 4'd9;

	// verdict codes
	localparam logic [1:0] VERDICT_OPEN = 2'd0;
	localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
	localparam logic [1:0] VERDICT_REJECT = 2'd2;

	typedef enum logic [9:0] {
		PH_FRAME_LEN   = 10'b00_0000_0001,
		PH_TYPE        = 10'b00_0000_0010,
		PH_PATH_LEN    = 10'b00_0000_0100,
		PH_PATH        = 10'b00_0000_1000,
		PH_PARAMS_LEN  = 10'b00_0001_0000,
		PH_PARAMS      = 10'b00_0010_0000,
		PH_PAYLOAD_LEN = 10'b00_0100_0000,
		PH_PAYLOAD     = 10'b00_1000_0000,
		PH_TRAILING    = 10'b01_0000_0000,
		PH_DISCARDED   = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic        frame_kind;
		logic [16:0] path_limit;
		logic [16:0] params_limit;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  byte_class;
		logic [7:0]  field_byte;
		logic [31:0] field_position;
		logic [1:0]  verdict;
		logic [31:0] consumed_bytes;
	} result_t;

	function automatic logic [3:0] phase_class(input phase_t ph);
		logic [3:0] cls;
		unique case (ph)
			PH_FRAME_LEN:   cls = CLS_FRAME_LEN;
			PH_TYPE:        cls = CLS_TYPE;
			PH_PATH_LEN:    cls = CLS_PATH_LEN;
			PH_PATH:        cls = CLS_PATH;
			PH_PARAMS_LEN:  cls = CLS_PARAMS_LEN;
			PH_PARAMS:      cls = CLS_PARAMS;
			PH_PAYLOAD_LEN: cls = CLS_PAYLOAD_LEN;
			PH_PAYLOAD:     cls = CLS_PAYLOAD;
			PH_TRAILING:    cls = CLS_TRAILING;
			default:        cls = CLS_DISCARDED;
		endcase
		return cls;
	endfunction

endpackage

@@ rtl/core/rrfp_cfg_regs.sv @@
// Configuration registers of the frame parser: layout kind and string limits.
// Depends on rrfp_pkg.
module rrfp_cfg_regs import rrfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_kind   <= 1'b0;
			cfg_q.path_limit   <= 17'd256;
			cfg_q.params_limit <= 17'd256;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_FRAME_KIND:   cfg_q.frame_kind <= cfg_wdata[0];
				REG_PATH_LIMIT:   cfg_q.path_limit <= cfg_wdata;
				REG_PARAMS_LIMIT: cfg_q.params_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/core/rrfp_parse_core.sv @@
// Parse state and per-byte next-state logic: classifies one byte, tracks
// field counters and judges the buffer on its last byte. Depends on rrfp_pkg.
module rrfp_parse_core import rrfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	input  cfg_t       cfg,
	output result_t    result
);

	localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

	phase_t      phase_q, ph0, ph_n;
	logic [31:0] cnt_q, cnt0, cnt_n, cnt_inc;
	logic [31:0] flen_q, flen_n;
	logic [31:0] dfl_q, dfl_n;
	logic [31:0] br_q, br_n;
	logic [31:0] pl_q, pl_n;
	logic        rej_q, rej0, rej_n;
	logic [31:0] len16, len32;
	logic [16:0] lim;
	logic        str_done;
	logic        ok;
	logic [3:0]  cls;

	always_comb begin
		// byte counter saturates; overflowing byte rejects the buffer
		ph0  = phase_q;
		cnt0 = cnt_q;
		rej0 = rej_q;
		br_n = br_q;
		if (br_q == U32_MAX) begin
			if (!rej_q) begin
				rej0 = 1'b1;
				ph0  = PH_DISCARDED;
				cnt0 = '0;
			end
		end else begin
			br_n = br_q + 32'd1;
		end

		cls     = phase_class(ph0);
		cnt_inc = (cnt0 == U32_MAX) ? cnt0 : cnt0 + 32'd1;
		len16   = (cnt0 == '0) ? {24'd0, data_byte} : {flen_q[23:0], data_byte};
		len32   = len16;
		lim     = (ph0 == PH_PATH_LEN) ? cfg.path_limit : cfg.params_limit;
		str_done = ({1'b0, cnt0} + 33'd1) >= {1'b0, flen_q};

		ph_n   = ph0;
		cnt_n  = cnt0;
		flen_n = flen_q;
		dfl_n  = dfl_q;
		pl_n   = pl_q;
		rej_n  = rej0;

		unique case (ph0)
			PH_FRAME_LEN: begin
				dfl_n = (cnt0 == '0) ? {24'd0, data_byte} : {dfl_q[23:0], data_byte};
				if (cnt0 >= 32'd3) begin
					ph_n  = PH_TYPE;
					cnt_n = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_TYPE: begin
				ph_n  = cfg.frame_kind ? PH_PARAMS_LEN : PH_PATH_LEN;
				cnt_n = '0;
			end
			PH_PATH_LEN, PH_PARAMS_LEN: begin
				flen_n = len16;
				if (cnt0 >= 32'd1) begin
					cnt_n = '0;
					if (len16 >= {15'd0, lim}) begin
						rej_n = 1'b1;
						ph_n  = PH_DISCARDED;
					end else if (len16 != '0) begin
						ph_n = (ph0 == PH_PATH_LEN) ? PH_PATH : PH_PARAMS;
					end else begin
						ph_n = (ph0 == PH_PATH_LEN) ? PH_PARAMS_LEN : PH_PAYLOAD_LEN;
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_PATH, PH_PARAMS: begin
				if (str_done) begin
					ph_n  = (ph0 == PH_PATH) ? PH_PARAMS_LEN : PH_PAYLOAD_LEN;
					cnt_n = '0;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_PAYLOAD_LEN: begin
				flen_n = len32;
				if (cnt0 >= 32'd3) begin
					cnt_n = '0;
					if (len32 != '0) begin
						ph_n = PH_PAYLOAD;
					end else begin
						ph_n = PH_TRAILING;
						pl_n = br_n;
					end
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_PAYLOAD: begin
				if (str_done) begin
					ph_n  = PH_TRAILING;
					cnt_n = '0;
					pl_n  = br_n;
				end else begin
					cnt_n = cnt_inc;
				end
			end
			PH_TRAILING:  cnt_n = cnt_inc;
			PH_DISCARDED: cnt_n = cnt_inc;
			default:      cnt_n = cnt_inc;
		endcase

		// frame length must fit in the buffer minus the length word
		ok = !rej_n && (ph_n == PH_TRAILING) &&
		     (({1'b0, dfl_n} + 33'd4) <= {1'b0, br_n});

		result.byte_class     = cls;
		result.field_byte     = data_byte;
		result.field_position = cnt0;
		result.verdict        = VERDICT_OPEN;
		result.consumed_bytes = '0;
		if (end_of_buffer) begin
			result.verdict        = ok ? VERDICT_ACCEPT : VERDICT_REJECT;
			result.consumed_bytes = ok ? pl_n : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FRAME_LEN;
			cnt_q   <= '0;
			flen_q  <= '0;
			dfl_q   <= '0;
			br_q    <= '0;
			pl_q    <= '0;
			rej_q   <= 1'b0;
		end else if (advance) begin
			if (end_of_buffer) begin
				phase_q <= PH_FRAME_LEN;
				cnt_q   <= '0;
				flen_q  <= '0;
				dfl_q   <= '0;
				br_q    <= '0;
				pl_q    <= '0;
				rej_q   <= 1'b0;
			end else begin
				phase_q <= ph_n;
				cnt_q   <= cnt_n;
				flen_q  <= flen_n;
				dfl_q   <= dfl_n;
				br_q    <= br_n;
				pl_q    <= pl_n;
				rej_q   <= rej_n;
			end
		end
	end

endmodule

@@ rtl/core/request_response_frame_parser.sv @@
// Top level of the request/response frame parser: input register, parse core,
// result register. Depends on rrfp_pkg, rrfp_cfg_regs and rrfp_parse_core.
//
// Takes one buffer byte per request and returns one tagged result per byte, at
// a sustained rate of one byte per clock cycle unless out_ready stalls the
// output side. Each byte goes through an input register and a result register,
// and a stalled output side holds both; the per-byte field counter update is
// the loop that sets this rate. The verdict and the consumed count ride on the
// result of the end-of-buffer byte, after which parse state starts afresh.
// Configuration writes are taken at any time but are meant for an idle block.
module request_response_frame_parser import rrfp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          data_byte,
	input  logic                end_of_buffer,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [3:0]          byte_class,
	output logic [7:0]          field_byte,
	output logic [31:0]         field_position,
	output logic [1:0]          verdict,
	output logic [31:0]         consumed_bytes
);

	cfg_t    cfg;
	result_t core_res;
	result_t res_s2;
	logic    valid_s1, valid_s2;
	logic [7:0] data_s1;
	logic    end_s1;
	logic    s2_free, adv_s1;

	assign s2_free  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;

	rrfp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			end_s1  <= end_of_buffer;
		end
	end

	rrfp_parse_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (adv_s1),
		.data_byte     (data_s1),
		.end_of_buffer (end_s1),
		.cfg           (cfg),
		.result        (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= core_res;
		end
	end

	assign out_valid      = valid_s2;
	assign byte_class     = res_s2.byte_class;
	assign field_byte     = res_s2.field_byte;
	assign field_position = res_s2.field_position;
	assign verdict        = res_s2.verdict;
	assign consumed_bytes = res_s2.consumed_bytes;

`ifndef SYNTHESIS
	// an accepted buffer ends on the payload tail, the payload length or trailing
	a_accept_class: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == VERDICT_ACCEPT) |->
		(byte_class == CLS_TRAILING || byte_class == CLS_PAYLOAD ||
		 byte_class == CLS_PAYLOAD_LEN))
		else $error("accepted verdict on unexpected byte class");

	a_accept_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict == VERDICT_ACCEPT) |-> (consumed_bytes != 32'd0))
		else $error("accepted verdict with zero consumed count");

	a_reject_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && verdict != VERDICT_ACCEPT) |-> (consumed_bytes == 32'd0))
		else $error("consumed count without accepted verdict");

	a_discard_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && byte_class == CLS_DISCARDED) |-> (verdict != VERDICT_ACCEPT))
		else $error("discarded byte carried an accepted verdict");
`endif

endmodule
